/* src/pls_pkg.sv */
package pls_pkg;

    localparam int ACTION_W       = 3;
    localparam int POS_W          = 7;
    localparam int ITEM_W         = 32;
    localparam int READ_W         = 32;
    localparam int CAPACITY_DEF   = 16;
    localparam int WORD_WIDTH_DEF = 32;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 3'd0,
        ACT_REMOVE = 3'd1,
        ACT_CLEAR  = 3'd2,
        ACT_GET    = 3'd3,
        ACT_SET    = 3'd4,
        ACT_FIND   = 3'd5
    } pls_action_t;

    typedef struct packed {
        logic              ok;
        logic [READ_W-1:0] read_word;
        logic [POS_W-1:0]  found_position;
        logic [POS_W-1:0]  count;
    } pls_result_t;

endpackage

/* src/pls_if.sv */
interface pls_req_if;
    import pls_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [POS_W-1:0]    position;
    logic [ITEM_W-1:0]   item_word;

    modport source (output valid, action, position, item_word, input ready);
    modport sink   (input valid, action, position, item_word, output ready);
endinterface

interface pls_rsp_if;
    import pls_pkg::*;

    logic              valid;
    logic              ready;
    logic              ok;
    logic [READ_W-1:0] read_word;
    logic [POS_W-1:0]  found_position;
    logic [POS_W-1:0]  count;

    modport source (output valid, ok, read_word, found_position, count, input ready);
    modport sink   (input valid, ok, read_word, found_position, count, output ready);
endinterface

/* src/positional_list_store_unit.sv */
// Positional list store: an ordered list of up to CAPACITY words, positions from 1.
// Channels: req carries one action per beat (insert, remove, clear, get, set,
// find) with a position and a word; rsp returns exactly one beat per request
// with ok, read_word, found_position and the list count after the action.
// One request is worked at a time; req.ready is high only while the sequencer
// is idle. Every step of the list walk goes through one single-port-read RAM
// with registered read data, so time per request follows the number of
// entries touched (N = count before the action, p = position):
//   clear, set, failed action, remove of the last entry: no list walk
//   get: one read of entry p
//   insert: entries p..N each read and written one place up, then word put at p
//   remove: entries p+1..N each read and written one place down
//   find: entries compared in order from 1 until a match or the end
// The response sits in an output register; while rsp.ready is low the held
// beat stays and the next finished request waits in the sequencer. Reset
// empties the list (count 0); stored words are not cleared.
module positional_list_store_unit #(
    parameter int CAPACITY   = pls_pkg::CAPACITY_DEF,
    parameter int WORD_WIDTH = pls_pkg::WORD_WIDTH_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    pls_req_if.sink  req,
    pls_rsp_if.source rsp
);
    import pls_pkg::*;

    localparam int ADDR_W = $clog2(CAPACITY);

    logic                  idle;
    logic                  emit;
    logic                  slot_free;
    pls_result_t           result;
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [WORD_WIDTH-1:0] ram_wdata;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [WORD_WIDTH-1:0] ram_rdata;
    logic                  out_valid_reg;
    pls_result_t           out_res_reg;

    assign req.ready = idle;
    assign slot_free = !out_valid_reg || rsp.ready;

    pls_ctrl #(
        .CAPACITY   (CAPACITY),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (req.valid && idle),
        .action    (req.action),
        .position  (req.position),
        .word      (WORD_WIDTH'(req.item_word)),
        .slot_free (slot_free),
        .idle      (idle),
        .emit      (emit),
        .result    (result),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    pls_ram #(
        .WIDTH (WORD_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_res_reg <= result;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.ok             = out_res_reg.ok;
    assign rsp.read_word      = out_res_reg.read_word;
    assign rsp.found_position = out_res_reg.found_position;
    assign rsp.count          = out_res_reg.count;

endmodule

/* src/pls_ram.sv */
module pls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/pls_ctrl.sv */
module pls_ctrl #(
    parameter int CAPACITY   = pls_pkg::CAPACITY_DEF,
    parameter int WORD_WIDTH = pls_pkg::WORD_WIDTH_DEF,
    localparam int ADDR_W    = $clog2(CAPACITY),
    localparam int CNT_W     = $clog2(CAPACITY + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pls_pkg::ACTION_W-1:0] action,
    input  logic [pls_pkg::POS_W-1:0]   position,
    input  logic [WORD_WIDTH-1:0]       word,
    input  logic                        slot_free,
    output logic                        idle,
    output logic                        emit,
    output pls_pkg::pls_result_t        result,
    output logic                        ram_we,
    output logic [ADDR_W-1:0]           ram_waddr,
    output logic [WORD_WIDTH-1:0]       ram_wdata,
    output logic [ADDR_W-1:0]           ram_raddr,
    input  logic [WORD_WIDTH-1:0]       ram_rdata
);
    import pls_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_UP_RD,
        ST_UP_WR,
        ST_INS_PUT,
        ST_DN_RD,
        ST_DN_WR,
        ST_GET_WAIT,
        ST_FIND_CMP,
        ST_DONE
    } state_t;

    state_t                 state_reg, state_next;
    pls_action_t            act_reg, act_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [WORD_WIDTH-1:0]  word_reg, word_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [ADDR_W-1:0]      idx_reg, idx_next;
    pls_result_t            res_reg, res_next;

    logic [POS_W-1:0]       pos_m1;
    logic [POS_W-1:0]       count_w;
    logic [CNT_W-1:0]       cnt_m1;
    logic [ADDR_W-1:0]      pos_idx;
    logic [ADDR_W-1:0]      idx_p1;
    logic [ADDR_W-1:0]      idx_m1;
    logic                   idx_last;
    logic                   pos_ok;
    logic                   ins_ok;

    assign pos_m1   = pos_reg - POS_W'(1);
    assign count_w  = POS_W'(count_reg);
    assign cnt_m1   = count_reg - CNT_W'(1);
    assign pos_idx  = pos_m1[ADDR_W-1:0];
    assign idx_p1   = idx_reg + ADDR_W'(1);
    assign idx_m1   = idx_reg - ADDR_W'(1);
    assign idx_last = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;
    assign pos_ok   = (pos_reg != '0) && (pos_reg <= count_w);
    assign ins_ok   = (pos_reg != '0) && (pos_reg <= count_w + POS_W'(1))
                      && (count_reg < CNT_W'(CAPACITY));

    always_comb
    begin
        state_next = state_reg;
        act_next   = act_reg;
        pos_next   = pos_reg;
        word_next  = word_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        res_next   = res_reg;
        ram_we     = 1'b0;
        ram_waddr  = idx_reg;
        ram_wdata  = word_reg;
        ram_raddr  = idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    act_next   = pls_action_t'(action);
                    pos_next   = position;
                    word_next  = word;
                    res_next   = '0;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_DONE;
                unique case (act_reg)
                    ACT_INSERT:
                    begin
                        if (ins_ok)
                        begin
                            res_next.ok = 1'b1;
                            if (pos_m1 == count_w)
                            begin
                                state_next = ST_INS_PUT;
                            end
                            else
                            begin
                                idx_next   = cnt_m1[ADDR_W-1:0];
                                state_next = ST_UP_RD;
                            end
                        end
                    end
                    ACT_REMOVE:
                    begin
                        if (pos_ok)
                        begin
                            res_next.ok = 1'b1;
                            if (pos_reg == count_w)
                            begin
                                count_next = cnt_m1;
                            end
                            else
                            begin
                                idx_next   = pos_reg[ADDR_W-1:0];
                                state_next = ST_DN_RD;
                            end
                        end
                    end
                    ACT_CLEAR:
                    begin
                        count_next  = '0;
                        res_next.ok = 1'b1;
                    end
                    ACT_GET:
                    begin
                        if (pos_ok)
                        begin
                            ram_raddr  = pos_idx;
                            state_next = ST_GET_WAIT;
                        end
                    end
                    ACT_SET:
                    begin
                        if (pos_ok)
                        begin
                            ram_we      = 1'b1;
                            ram_waddr   = pos_idx;
                            res_next.ok = 1'b1;
                        end
                    end
                    ACT_FIND:
                    begin
                        res_next.ok = 1'b1;
                        if (count_reg != '0)
                        begin
                            ram_raddr  = '0;
                            idx_next   = '0;
                            state_next = ST_FIND_CMP;
                        end
                    end
                    default:
                    begin
                        res_next.ok = 1'b0;
                    end
                endcase
            end
            ST_UP_RD:
            begin
                state_next = ST_UP_WR;
            end
            ST_UP_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_p1;
                ram_wdata = ram_rdata;
                if (POS_W'(idx_reg) == pos_m1)
                begin
                    state_next = ST_INS_PUT;
                end
                else
                begin
                    idx_next   = idx_m1;
                    state_next = ST_UP_RD;
                end
            end
            ST_INS_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = pos_idx;
                count_next = count_reg + CNT_W'(1);
                state_next = ST_DONE;
            end
            ST_DN_RD:
            begin
                state_next = ST_DN_WR;
            end
            ST_DN_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_m1;
                ram_wdata = ram_rdata;
                if (idx_last)
                begin
                    count_next = cnt_m1;
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next   = idx_p1;
                    state_next = ST_DN_RD;
                end
            end
            ST_GET_WAIT:
            begin
                res_next.ok        = 1'b1;
                res_next.read_word = READ_W'(ram_rdata);
                state_next         = ST_DONE;
            end
            ST_FIND_CMP:
            begin
                if (ram_rdata == word_reg)
                begin
                    res_next.found_position = POS_W'(idx_reg) + POS_W'(1);
                    state_next              = ST_DONE;
                end
                else if (idx_last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    ram_raddr = idx_p1;
                    idx_next  = idx_p1;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            act_reg   <= ACT_INSERT;
            pos_reg   <= '0;
            word_reg  <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            act_reg   <= act_next;
            pos_reg   <= pos_next;
            word_reg  <= word_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            res_reg   <= res_next;
        end
    end

    assign idle = (state_reg == ST_IDLE);
    assign emit = (state_reg == ST_DONE) && slot_free;

    always_comb
    begin
        result       = res_reg;
        result.count = POS_W'(count_reg);
    end

    a_count_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |=> (count_reg == $past(count_reg)))
        else $error("list count changed while idle");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (CNT_W'(ram_waddr) <= count_reg))
        else $error("write beyond end of list");

    a_found_only_find: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && (result.found_position != '0)) |-> ((act_reg == ACT_FIND) && result.ok))
        else $error("found position on a non-find action");

    a_read_only_get: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && (result.read_word != '0)) |-> ((act_reg == ACT_GET) && result.ok))
        else $error("read word on a non-get action");

endmodule
